// ----- src/pic_pkg.sv -----
package pic_pkg;

    localparam int unsigned WordWidth  = 64;
    localparam int unsigned CountWidth = 4;
    localparam int unsigned TotalWidth = 32;
    localparam int unsigned SumOutWidth = 32;
    localparam int unsigned LaneWidth  = 16;
    localparam int unsigned BytesPerWord = WordWidth / 8;
    localparam logic [CountWidth-1:0] FullCount = CountWidth'(BytesPerWord);

    // One masked image word waiting in the input register
    typedef struct packed {
        logic [WordWidth-1:0]  word;
        logic [CountWidth-1:0] nb;
        logic                  last;
    } word_item_t;

    // Final state of one image, waiting for the fold
    typedef struct packed {
        logic [WordWidth-1:0]  sum;
        logic [TotalWidth-1:0] total;
    } image_item_t;

    // Fold a 64-bit ones'-complement sum to 16 bits, wrapping every carry
    function automatic logic [LaneWidth-1:0] fold16(input logic [WordWidth-1:0] s);
        logic [LaneWidth+1:0] lanes;
        logic [LaneWidth:0]   x1;
        logic [LaneWidth:0]   x2;
        begin
            lanes = {2'b00, s[15:0]} + {2'b00, s[31:16]}
                  + {2'b00, s[47:32]} + {2'b00, s[63:48]};
            x1 = {1'b0, lanes[LaneWidth-1:0]} + {15'b0, lanes[LaneWidth+1:LaneWidth]};
            x2 = {1'b0, x1[LaneWidth-1:0]} + {16'b0, x1[LaneWidth]};
            fold16 = x2[LaneWidth-1:0];
        end
    endfunction

endpackage

// ----- src/pic_input_stage.sv -----
module pic_input_stage
    import pic_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [WordWidth-1:0]  data_word,
    input  logic [CountWidth-1:0] valid_bytes,
    input  logic                  last_word,
    input  logic                  a_drain,
    output logic                  a_valid,
    output word_item_t            a_item
);

    logic       a_valid_reg;
    logic       a_valid_next;
    word_item_t a_item_reg;
    word_item_t a_item_next;
    logic [CountWidth-1:0] nb_clamped;
    logic [WordWidth-1:0]  byte_mask;

    // Clamp counts above a full word, then keep only the valid low bytes
    assign nb_clamped = valid_bytes[CountWidth-1] ? FullCount : valid_bytes;

    always_comb
    begin
        for (int k = 0; k < BytesPerWord; k++)
        begin
            byte_mask[k*8 +: 8] = (CountWidth'(k) < nb_clamped) ? 8'hff : 8'h00;
        end
    end

    assign in_stall = a_valid_reg && !a_drain;

    always_comb
    begin
        a_item_next.word = data_word & byte_mask;
        a_item_next.nb   = nb_clamped;
        a_item_next.last = last_word;
        a_valid_next     = in_stall ? a_valid_reg : in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            a_item_reg <= a_item_next;
        end
    end

    assign a_valid = a_valid_reg;
    assign a_item  = a_item_reg;

endmodule

// ----- src/pic_accum.sv -----
module pic_accum
    import pic_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        a_valid,
    input  word_item_t  a_item,
    output logic        a_drain,
    input  logic        b_take,
    output logic        b_valid,
    output image_item_t b_item
);

    logic [WordWidth-1:0]  sum_reg;
    logic [WordWidth-1:0]  sum_next;
    logic [TotalWidth-1:0] total_reg;
    logic [TotalWidth-1:0] total_next;
    logic                  b_valid_reg;
    logic                  b_valid_next;
    image_item_t           b_item_reg;
    logic                  b_ready;
    logic [WordWidth:0]    raw_sum;

    // A last word needs the image slot free; other words always fold in
    assign b_ready = !b_valid_reg || b_take;
    assign a_drain = a_valid && (!a_item.last || b_ready);

    // Add with end-around carry
    always_comb
    begin
        raw_sum    = {1'b0, sum_reg} + {1'b0, a_item.word};
        sum_next   = raw_sum[WordWidth-1:0] + {{(WordWidth-1){1'b0}}, raw_sum[WordWidth]};
        total_next = total_reg + {{(TotalWidth-CountWidth){1'b0}}, a_item.nb};
    end

    always_comb
    begin
        b_valid_next = b_valid_reg;
        if (b_take)
        begin
            b_valid_next = 1'b0;
        end
        if (a_drain && a_item.last)
        begin
            b_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg     <= '0;
            total_reg   <= '0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= b_valid_next;
            if (a_drain)
            begin
                if (a_item.last)
                begin
                    sum_reg   <= '0;
                    total_reg <= '0;
                end
                else
                begin
                    sum_reg   <= sum_next;
                    total_reg <= total_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_drain && a_item.last)
        begin
            b_item_reg.sum   <= sum_next;
            b_item_reg.total <= total_next;
        end
    end

    assign b_valid = b_valid_reg;
    assign b_item  = b_item_reg;

endmodule

// ----- src/pic_fold_out.sv -----
module pic_fold_out
    import pic_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   b_valid,
    input  image_item_t            b_item,
    output logic                   b_take,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [SumOutWidth-1:0] checksum
);

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [SumOutWidth-1:0] checksum_reg;
    logic [SumOutWidth-1:0] checksum_next;
    logic                   out_ready;

    assign out_ready = !out_valid_reg || !out_stall;
    assign b_take    = b_valid && out_ready;

    always_comb
    begin
        checksum_next  = {{(SumOutWidth-LaneWidth){1'b0}}, fold16(b_item.sum)}
                       + b_item.total;
        out_valid_next = out_ready ? b_valid : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_take)
        begin
            checksum_reg <= checksum_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign checksum  = checksum_reg;

endmodule

// ----- src/pe_image_checksum_core.sv -----
// Image checksum engine. Stream the image as 64-bit little-endian words (first
// byte in bits 7:0); valid_bytes gives the count of valid low bytes, counts above
// eight count as eight, and the unused high bytes are masked to zero. Each word
// is added into a 64-bit ones'-complement sum with end-around carry and its byte
// count into a 32-bit total. On the word marked last_word the sum is folded to
// 16 bits, the byte total is added modulo 2^32, one checksum transaction is
// emitted and the running state clears for the next image. Zero the header's
// checksum field in the stream before sending it. The block takes one word per
// cycle unless in_stall is high; after its last word is accepted, a checksum
// passes three register stages: input register, accumulator (the 64-bit
// end-around add), fold and output register. The registers decouple the sides,
// so words keep flowing while a finished checksum waits to be taken; a further
// last word holds only while both the image slot and the output are full.
module pe_image_checksum_core
    import pic_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [WordWidth-1:0]   data_word,
    input  logic [CountWidth-1:0]  valid_bytes,
    input  logic                   last_word,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [SumOutWidth-1:0] checksum
);

    logic        a_valid;
    logic        a_drain;
    word_item_t  a_item;
    logic        b_valid;
    logic        b_take;
    image_item_t b_item;

    // Mask and hold one word per transaction
    pic_input_stage u_input_stage
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_word   (data_word),
        .valid_bytes (valid_bytes),
        .last_word   (last_word),
        .a_drain     (a_drain),
        .a_valid     (a_valid),
        .a_item      (a_item)
    );

    // Accumulate; hand the finished image state forward on a last word
    pic_accum u_accum
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .a_valid (a_valid),
        .a_item  (a_item),
        .a_drain (a_drain),
        .b_take  (b_take),
        .b_valid (b_valid),
        .b_item  (b_item)
    );

    // Fold, add the byte total and hold the result
    pic_fold_out u_fold_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .b_valid   (b_valid),
        .b_item    (b_item),
        .b_take    (b_take),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .checksum  (checksum)
    );

    // Stall the input only while a held word cannot advance
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> a_valid)
        else $error("input stalled with empty input register");

    // A held last word must wait while the image slot is busy and not emptying
    assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid && a_item.last && b_valid && !b_take) |-> in_stall)
        else $error("last word accepted over a pending image");

    // Drop no pending image while the output is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid && !b_take) |=> b_valid)
        else $error("pending image lost");

    // Clear the output slot once the transaction completes, unless it is refilled
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !b_valid) |=> !out_valid)
        else $error("checksum repeated after transaction");

endmodule

// ----- bench/pe_image_checksum_core_tb.sv -----
`timescale 1ns / 1ps

module pe_image_checksum_core_tb;

    import pic_pkg::*;

    localparam int unsigned RandomWords    = 1700;
    localparam int unsigned LongHoldCycles = 200;
    localparam int unsigned DrainCycles    = 8;
    localparam int unsigned MaxReports     = 10;
    localparam logic [WordWidth-1:0] AllOnes = '1;

    // One row of the directed table; known marks rows whose checksum is typed in
    typedef struct packed {
        logic [WordWidth-1:0]   word;
        logic [CountWidth-1:0]  nb;
        logic                   last;
        logic                   known;
        logic [SumOutWidth-1:0] sum;
    } word_row_t;

    localparam int unsigned DirectedRows = 22;

    // Single-word images first, so each typed checksum but the last reads straight off one word
    word_row_t directed_rows [DirectedRows] = '{
        // zero image right after reset: only the byte count shows
        '{64'h0, 4'd8, 1'b1, 1'b1, 32'h0000_0008},
        // all ones, full word: lanes fold to 0xffff
        '{AllOnes, 4'd8, 1'b1, 1'b1, 32'h0001_0007},
        // zero valid bytes on a last word still closes the image
        '{AllOnes, 4'd0, 1'b1, 1'b1, 32'h0000_0000},
        // a count above eight counts as eight
        '{AllOnes, 4'd15, 1'b1, 1'b1, 32'h0001_0007},
        // one byte: everything above bits 7:0 is masked
        '{AllOnes, 4'd1, 1'b1, 1'b1, 32'h0000_0100},
        // lane carries wrap around in the fold
        '{64'h8000_8000_8000_8000, 4'd8, 1'b1, 1'b1, 32'h0000_000a},
        // 64-bit end-around carry across two words
        '{AllOnes, 4'd8, 1'b0, 1'b0, 32'h0},
        '{64'h1, 4'd8, 1'b1, 1'b1, 32'h0000_0011},
        // partial and empty words in the middle of an image
        '{64'h0123_4567_89ab_cdef, 4'd3, 1'b0, 1'b0, 32'h0},
        '{64'hfedc_ba98_7654_3210, 4'd0, 1'b0, 1'b0, 32'h0},
        '{64'h5555_5555_5555_5555, 4'd12, 1'b0, 1'b0, 32'h0},
        '{64'haaaa_aaaa_aaaa_aaaa, 4'd2, 1'b1, 1'b0, 32'h0},
        // remaining byte counts on last words
        '{64'h0102_0304_0506_0708, 4'd4, 1'b1, 1'b0, 32'h0},
        '{64'hf0e1_d2c3_b4a5_9687, 4'd5, 1'b1, 1'b0, 32'h0},
        '{64'h8877_6655_4433_2211, 4'd6, 1'b1, 1'b0, 32'h0},
        '{AllOnes, 4'd7, 1'b1, 1'b0, 32'h0},
        // multi-word images, the first with a count above eight on the last word
        '{AllOnes, 4'd7, 1'b0, 1'b0, 32'h0},
        '{AllOnes, 4'd9, 1'b1, 1'b0, 32'h0},
        '{64'hdead_beef_cafe_f00d, 4'd8, 1'b0, 1'b0, 32'h0},
        '{64'h0f0f_0f0f_0f0f_0f0f, 4'd8, 1'b0, 1'b0, 32'h0},
        '{64'hffff_0000_ffff_0000, 4'd8, 1'b0, 1'b0, 32'h0},
        '{64'h7fff_ffff_ffff_ffff, 4'd8, 1'b1, 1'b0, 32'h0}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [WordWidth-1:0]   data_word;
    logic [CountWidth-1:0]  valid_bytes;
    logic                   last_word;
    logic                   out_valid;
    logic                   out_stall;
    logic [SumOutWidth-1:0] checksum;

    // Typed checksum that travels with the word on the input side
    logic                   row_known;
    logic [SumOutWidth-1:0] row_sum;

    // Predicted image state and the checksums still owed by the block
    logic [WordWidth-1:0]   image_sum;
    logic [TotalWidth-1:0]  image_bytes;
    logic [SumOutWidth-1:0] expected_checksums [$];

    int unsigned error_count;
    int unsigned words_accepted;
    int unsigned images_closed;
    int unsigned checksums_seen;
    int unsigned words_offered;

    bit sender_idle_on;
    bit receiver_stall_on;
    bit long_hold_pending;

    pe_image_checksum_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_word   (data_word),
        .valid_bytes (valid_bytes),
        .last_word   (last_word),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .checksum    (checksum)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop in case the block hangs; far beyond the slowest correct run
    initial
    begin
        #4_000_000;
        $display("pe_image_checksum_core test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Keep the low valid bytes, zero the rest; counts above eight saturate
    function automatic logic [WordWidth-1:0] keep_low_bytes(
        input logic [WordWidth-1:0] w, input int unsigned n);
        logic [WordWidth-1:0] kept;
        kept = '0;
        for (int b = 0; b < BytesPerWord; b++)
        begin
            if (b < n)
                kept[b*8 +: 8] = w[b*8 +: 8];
        end
        return kept;
    endfunction

    // 64-bit add with the carry out fed back into bit 0
    function automatic logic [WordWidth-1:0] add_wrap(
        input logic [WordWidth-1:0] a, input logic [WordWidth-1:0] b);
        logic [WordWidth:0] t;
        t = {1'b0, a} + {1'b0, b};
        return t[WordWidth-1:0] + t[WordWidth];
    endfunction

    // Sum the four 16-bit lanes and fold twice, so no carry is lost
    function automatic logic [LaneWidth-1:0] fold_lanes(input logic [WordWidth-1:0] s);
        int unsigned acc;
        acc = 0;
        for (int k = 0; k < WordWidth / LaneWidth; k++)
            acc += s[k*LaneWidth +: LaneWidth];
        repeat (2) acc = (acc & 32'h0000_ffff) + (acc >> LaneWidth);
        return acc[LaneWidth-1:0];
    endfunction

    task automatic note_failure(input string what, input logic [SumOutWidth-1:0] want,
                                input logic [SumOutWidth-1:0] got);
        if (error_count < MaxReports)
            $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
        error_count++;
    endtask

    // Watch both handshakes at every edge. Check the result side first, then
    // fold any accepted word into the predicted state; a last word queues the
    // checksum for its image (the typed value where the table gives one).
    always @(posedge clk)
    begin
        logic [SumOutWidth-1:0] want;
        int unsigned n;
        if (rst_n && out_valid && !out_stall)
        begin
            checksums_seen++;
            if (expected_checksums.size() == 0)
                note_failure("checksum with no image closed", '0, checksum);
            else
            begin
                want = expected_checksums.pop_front();
                if (checksum !== want)
                    note_failure("checksum mismatch", want, checksum);
            end
        end
        if (rst_n && in_valid && !in_stall)
        begin
            words_accepted++;
            n = (valid_bytes > FullCount) ? BytesPerWord : valid_bytes;
            image_sum = add_wrap(image_sum, keep_low_bytes(data_word, n));
            image_bytes = image_bytes + TotalWidth'(n);
            if (last_word)
            begin
                want = SumOutWidth'(fold_lanes(image_sum)) + image_bytes;
                expected_checksums.push_back(row_known ? row_sum : want);
                images_closed++;
                image_sum = '0;
                image_bytes = '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Idle and stall lengths: mostly none or short, now and then long
    // ------------------------------------------------------------------
    function automatic int unsigned idle_gap(input bit enabled);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Result side: random stall runs, plus one long hold-off on request,
    // counted here so the sender keeps offering words meanwhile
    initial
    begin : receiver
        int unsigned run;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_pending)
            begin
                out_stall <= 1'b1;
                repeat (LongHoldCycles) @(posedge clk);
                long_hold_pending = 1'b0;
                out_stall <= 1'b0;
            end
            else if (receiver_stall_on && $urandom_range(0, 99) < 30)
            begin
                run = idle_gap(1'b1);
                if (run == 0)
                    run = 1;
                out_stall <= 1'b1;
                repeat (run) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offer one word and hold it until the block takes it. Drop valid only
    // for a real gap, so back-to-back words keep valid high.
    task automatic offer_word(input logic [WordWidth-1:0] w, input logic [CountWidth-1:0] nb,
                              input logic lw, input logic known,
                              input logic [SumOutWidth-1:0] sum);
        int unsigned gap;
        gap = idle_gap(sender_idle_on);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        data_word   <= w;
        valid_bytes <= nb;
        last_word   <= lw;
        row_known   <= known;
        row_sum     <= sum;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        words_offered++;
    endtask

    // Go quiet until every queued checksum has come back, then let the
    // pipeline settle. Let the current edge pass first so the last accepted word is counted.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_checksums.size() != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    function automatic logic [WordWidth-1:0] pick_word();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return AllOnes;
        if (r < 15)
            return '0;
        return {$urandom, $urandom};
    endfunction

    // One image with random content. Well-formed images carry full words up
    // to a last word of 1..8 bytes; noisy ones add empty, partial or
    // oversized counts anywhere.
    task automatic send_image(input int unsigned len, input bit noisy);
        logic [CountWidth-1:0] nb;
        logic lw;
        for (int unsigned i = 0; i < len; i++)
        begin
            lw = (i == len - 1);
            if (noisy && $urandom_range(0, 3) == 0)
                nb = CountWidth'($urandom_range(0, 15));
            else if (lw)
                nb = CountWidth'($urandom_range(1, 8));
            else
                nb = FullCount;
            offer_word(pick_word(), nb, lw, 1'b0, '0);
        end
    endtask

    function automatic int unsigned image_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 8);
        if (r < 97)
            return $urandom_range(9, 40);
        return $urandom_range(100, 200);
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        bit hold_done;
        bit pause_done;
        int unsigned burst_start;
        in_valid          = 1'b0;
        data_word         = '0;
        valid_bytes       = '0;
        last_word         = 1'b0;
        row_known         = 1'b0;
        row_sum           = '0;
        image_sum         = '0;
        image_bytes       = '0;
        error_count       = 0;
        words_accepted    = 0;
        images_closed     = 0;
        checksums_seen    = 0;
        words_offered     = 0;
        sender_idle_on    = 1'b0;
        receiver_stall_on = 1'b0;
        long_hold_pending = 1'b0;
        hold_done         = 1'b0;
        pause_done        = 1'b0;

        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table back to back, then let it drain
        foreach (directed_rows[i])
            offer_word(directed_rows[i].word, directed_rows[i].nb, directed_rows[i].last,
                       directed_rows[i].known, directed_rows[i].sum);
        wait_for_drain();

        // Random images. Start with a clean stretch at full rate, then turn
        // idling on both sides and flip it now and then for quiet stretches.
        words_offered = 0;
        while (words_offered < RandomWords)
        begin
            if (words_offered >= 250 && words_offered < 300)
            begin
                sender_idle_on    = 1'b1;
                receiver_stall_on = 1'b1;
            end
            else if (words_offered >= 300 && $urandom_range(0, 15) == 0)
                sender_idle_on = ~sender_idle_on;
            else if (words_offered >= 300 && $urandom_range(0, 15) == 0)
                receiver_stall_on = ~receiver_stall_on;

            if (!hold_done && words_offered >= 600)
            begin
                // Hold the result side off while short images keep coming at
                // full rate, so finished checksums back up into the input
                hold_done = 1'b1;
                long_hold_pending = 1'b1;
                sender_idle_on = 1'b0;
                burst_start = words_offered;
                while (words_offered - burst_start < 60)
                    send_image($urandom_range(1, 2), 1'b0);
                sender_idle_on = 1'b1;
            end
            else if (!pause_done && words_offered >= 1100)
            begin
                pause_done = 1'b1;
                wait_for_drain();
            end
            else
                send_image(image_length(), $urandom_range(0, 9) == 0);
        end

        wait_for_drain();

        $display("Streamed %0d words in %0d images (%0d directed rows), %0d checksums checked",
                 words_accepted, images_closed, DirectedRows, checksums_seen);
        $display("Covered masking of every byte count, end-around and fold carries, ",
                 "idle gaps, stalls and a %0d-cycle hold-off", LongHoldCycles);
        if (error_count == 0)
            $display("pe_image_checksum_core test passed");
        else
            $display("pe_image_checksum_core test failed");
        $finish;
    end

endmodule
